// File: design/brp_pkg.sv
// ----------------------------------------------------------------------------
// brp_pkg: shared types and constants of the byte range parser
// Phase and spec-state encodings, character codes and the result flag group.
// ----------------------------------------------------------------------------
package brp_pkg;

    // header parse phase, one-hot
    typedef enum logic [4:0] {
        PH_LEAD   = 5'b00001,
        PH_UNIT   = 5'b00010,
        PH_MID    = 5'b00100,
        PH_SET    = 5'b01000,
        PH_IGNORE = 5'b10000
    } t_phase;

    // range spec state, one-hot
    typedef enum logic [2:0] {
        SP_START  = 3'b001,
        SP_FIRST  = 3'b010,
        SP_SECOND = 3'b100
    } t_spec;

    // flags of one result item
    typedef struct packed {
        logic emit;
        logic range_valid;
        logic first_present;
        logic last_present;
        logic done;
        logic status;
    } t_flags;

    // character codes
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // length of the unit token "bytes"
    localparam logic [2:0] UNIT_LEN = 3'd5;

    // letter of the unit token at a position
    function automatic logic [7:0] unit_letter(input logic [2:0] idx);
        logic [7:0] res;
        case (idx)
            3'd0:    res = 8'h62; // b
            3'd1:    res = 8'h79; // y
            3'd2:    res = 8'h74; // t
            3'd3:    res = 8'h65; // e
            3'd4:    res = 8'h73; // s
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

// File: design/brp_in_reg.sv
// ----------------------------------------------------------------------------
// brp_in_reg: input register
// Holds one incoming item until the parse stage takes it.
// ----------------------------------------------------------------------------
module brp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_value,
    input  logic       i_advance,
    output logic       o_item_valid,
    output logic [7:0] o_char_code,
    output logic       o_end_of_value
);

    logic       r_valid;
    logic [7:0] r_char_code;
    logic       r_end_of_value;
    logic       w_load;

    // register is free when empty or when its item moves on
    assign o_stall = r_valid && !i_advance;
    assign w_load  = i_valid && !o_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char_code    <= i_char_code;
            r_end_of_value <= i_end_of_value;
        end
    end

    assign o_item_valid   = r_valid;
    assign o_char_code    = r_char_code;
    assign o_end_of_value = r_end_of_value;

endmodule

// File: design/brp_dec_acc.sv
// ----------------------------------------------------------------------------
// brp_dec_acc: saturating decimal accumulate
// Computes acc * 10 + digit, clamped at the largest position value.
// ----------------------------------------------------------------------------
module brp_dec_acc #(
    parameter int POS_BITS = 48
) (
    input  logic [POS_BITS-1:0] i_acc,
    input  logic [3:0]          i_digit,
    output logic [POS_BITS-1:0] o_acc
);

    localparam int W = POS_BITS + 4;

    logic [W-1:0] w_ext;
    logic [W-1:0] w_sum;

    // times ten as two shifts and an add, plus the digit
    assign w_ext = {4'b0000, i_acc};
    assign w_sum = (w_ext << 3) + (w_ext << 1) + {{(W-4){1'b0}}, i_digit};

    // any bit above the field means overflow
    assign o_acc = (|w_sum[W-1:POS_BITS]) ? {POS_BITS{1'b1}} : w_sum[POS_BITS-1:0];

endmodule

// File: design/brp_core.sv
// ----------------------------------------------------------------------------
// brp_core: parse state and next-state logic
// Tracks unit matching, range spec fields and error, and forms the result.
// ----------------------------------------------------------------------------
module brp_core #(
    parameter int POS_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [7:0]            i_char_code,
    input  logic                  i_end_of_value,
    output brp_pkg::t_flags       o_flags,
    output logic [POS_BITS-1:0]   o_first_pos,
    output logic [POS_BITS-1:0]   o_last_pos
);

    brp_pkg::t_phase     r_phase, n_phase;
    logic [2:0]          r_unit_index, n_unit_index;
    logic                r_unit_mismatch, n_unit_mismatch;
    brp_pkg::t_spec      r_spec, n_spec;
    logic [POS_BITS-1:0] r_first_acc, n_first_acc;
    logic                r_first_seen, n_first_seen;
    logic [POS_BITS-1:0] r_second_acc, n_second_acc;
    logic                r_second_seen, n_second_seen;
    logic                r_error, n_error;

    logic [POS_BITS-1:0] w_first_step;
    logic [POS_BITS-1:0] w_second_step;
    logic                w_digit;
    logic [3:0]          w_dval;
    logic                w_give;
    logic                w_status;

    assign w_digit = (i_char_code >= brp_pkg::CH_ZERO) && (i_char_code <= brp_pkg::CH_NINE);
    assign w_dval  = i_char_code[3:0];

    // decimal accumulators for both positions
    brp_dec_acc #(.POS_BITS(POS_BITS)) u_first_acc (
        .i_acc   (r_first_acc),
        .i_digit (w_dval),
        .o_acc   (w_first_step)
    );

    brp_dec_acc #(.POS_BITS(POS_BITS)) u_second_acc (
        .i_acc   (r_second_acc),
        .i_digit (w_dval),
        .o_acc   (w_second_step)
    );

    // next state and result
    always_comb begin
        logic fin;
        logic set_ch;
        logic unit_ch;

        n_phase         = r_phase;
        n_unit_index    = r_unit_index;
        n_unit_mismatch = r_unit_mismatch;
        n_spec          = r_spec;
        n_first_acc     = r_first_acc;
        n_first_seen    = r_first_seen;
        n_second_acc    = r_second_acc;
        n_second_seen   = r_second_seen;
        n_error         = r_error;
        fin             = 1'b0;
        set_ch          = 1'b0;
        unit_ch         = 1'b0;
        w_give          = 1'b0;

        // phase walk
        if (i_end_of_value) begin
            fin = (r_phase == brp_pkg::PH_SET);
        end else begin
            unique case (r_phase)
                brp_pkg::PH_LEAD: begin
                    if (i_char_code != brp_pkg::CH_EQ) begin
                        n_phase = brp_pkg::PH_UNIT;
                        unit_ch = 1'b1;
                    end
                end
                brp_pkg::PH_UNIT: begin
                    if (i_char_code == brp_pkg::CH_EQ) begin
                        if (r_unit_mismatch || (r_unit_index != brp_pkg::UNIT_LEN)) begin
                            n_phase = brp_pkg::PH_IGNORE;
                        end else begin
                            n_phase = brp_pkg::PH_MID;
                        end
                    end else begin
                        unit_ch = 1'b1;
                    end
                end
                brp_pkg::PH_MID: begin
                    if (i_char_code != brp_pkg::CH_EQ) begin
                        n_phase = brp_pkg::PH_SET;
                        set_ch  = 1'b1;
                    end
                end
                brp_pkg::PH_SET: begin
                    if (i_char_code == brp_pkg::CH_EQ) begin
                        fin     = 1'b1;
                        n_phase = brp_pkg::PH_IGNORE;
                    end else begin
                        set_ch = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // unit token compare
        if (unit_ch) begin
            if (r_unit_index < brp_pkg::UNIT_LEN) begin
                if (brp_pkg::unit_letter(r_unit_index) != i_char_code) begin
                    n_unit_mismatch = 1'b1;
                end
                n_unit_index = r_unit_index + 3'd1;
            end else begin
                n_unit_mismatch = 1'b1;
            end
        end

        // range set character
        if (set_ch && !r_error) begin
            if (i_char_code == brp_pkg::CH_COMMA) begin
                fin = 1'b1;
            end else begin
                unique case (r_spec)
                    brp_pkg::SP_START: begin
                        if (w_digit) begin
                            n_first_acc  = {{(POS_BITS-4){1'b0}}, w_dval};
                            n_first_seen = 1'b1;
                            n_spec       = brp_pkg::SP_FIRST;
                        end else if (i_char_code == brp_pkg::CH_DASH) begin
                            n_spec = brp_pkg::SP_SECOND;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    brp_pkg::SP_FIRST: begin
                        if (w_digit) begin
                            n_first_acc = w_first_step;
                        end else if (i_char_code == brp_pkg::CH_DASH) begin
                            n_spec = brp_pkg::SP_SECOND;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    default: begin
                        if (w_digit) begin
                            n_second_acc  = w_second_step;
                            n_second_seen = 1'b1;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                endcase
            end
        end

        // close the current spec
        if (fin) begin
            if (!r_error) begin
                if (r_spec == brp_pkg::SP_FIRST) begin
                    n_error = 1'b1;
                end else if (r_spec == brp_pkg::SP_SECOND) begin
                    w_give = 1'b1;
                end
            end
            n_spec        = brp_pkg::SP_START;
            n_first_acc   = '0;
            n_first_seen  = 1'b0;
            n_second_acc  = '0;
            n_second_seen = 1'b0;
        end

        w_status = n_error;

        // end marker returns everything to reset
        if (i_end_of_value) begin
            n_phase         = brp_pkg::PH_LEAD;
            n_unit_index    = 3'd0;
            n_unit_mismatch = 1'b0;
            n_spec          = brp_pkg::SP_START;
            n_first_acc     = '0;
            n_first_seen    = 1'b0;
            n_second_acc    = '0;
            n_second_seen   = 1'b0;
            n_error         = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= brp_pkg::PH_LEAD;
            r_unit_index    <= 3'd0;
            r_unit_mismatch <= 1'b0;
            r_spec          <= brp_pkg::SP_START;
            r_first_acc     <= '0;
            r_first_seen    <= 1'b0;
            r_second_acc    <= '0;
            r_second_seen   <= 1'b0;
            r_error         <= 1'b0;
        end else if (i_fire) begin
            r_phase         <= n_phase;
            r_unit_index    <= n_unit_index;
            r_unit_mismatch <= n_unit_mismatch;
            r_spec          <= n_spec;
            r_first_acc     <= n_first_acc;
            r_first_seen    <= n_first_seen;
            r_second_acc    <= n_second_acc;
            r_second_seen   <= n_second_seen;
            r_error         <= n_error;
        end
    end

    // result fields; range fields are zero where no range is carried
    always_comb begin
        o_flags.emit          = w_give || i_end_of_value;
        o_flags.range_valid   = w_give;
        o_flags.first_present = w_give && r_first_seen;
        o_flags.last_present  = w_give && r_second_seen;
        o_flags.done          = i_end_of_value;
        o_flags.status        = i_end_of_value && w_status;
    end

    assign o_first_pos = w_give ? r_first_acc : '0;
    assign o_last_pos  = w_give ? r_second_acc : '0;

endmodule

// File: design/brp_out_reg.sv
// ----------------------------------------------------------------------------
// brp_out_reg: result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module brp_out_reg #(
    parameter int POS_BITS = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  brp_pkg::t_flags     i_flags,
    input  logic [POS_BITS-1:0] i_first_pos,
    input  logic [POS_BITS-1:0] i_last_pos,
    output logic                o_advance,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_range_valid,
    output logic                o_first_present,
    output logic [POS_BITS-1:0] o_first_pos,
    output logic                o_last_present,
    output logic [POS_BITS-1:0] o_last_pos,
    output logic                o_done_res,
    output logic                o_status
);

    logic                r_valid;
    brp_pkg::t_flags     r_flags;
    logic [POS_BITS-1:0] r_first_pos;
    logic [POS_BITS-1:0] r_last_pos;

    // register can take a new item when empty or being drained
    assign o_advance = !r_valid || !i_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire && i_flags.emit;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_flags     <= i_flags;
            r_first_pos <= i_first_pos;
            r_last_pos  <= i_last_pos;
        end
    end

    assign o_valid         = r_valid;
    assign o_range_valid   = r_flags.range_valid;
    assign o_first_present = r_flags.first_present;
    assign o_first_pos     = r_first_pos;
    assign o_last_present  = r_flags.last_present;
    assign o_last_pos      = r_last_pos;
    assign o_done_res      = r_flags.done;
    assign o_status        = r_flags.status;

endmodule

// File: design/http_byte_range_parser_top.sv
// path: item held in the input register, parsed, result held in the result register
// throughput: one item per cycle unless results stall, set by the single parse stage
// an item gives at most one result; items that give none leave no gap
// reset: synchronous active-low; clears both registers and the parse state
// ----------------------------------------------------------------------------
// http_byte_range_parser_top: HTTP Range header value parser
// Parses "bytes=" range sets one character per item and gives out each complete spec.
// ----------------------------------------------------------------------------
module http_byte_range_parser_top #(
    parameter int POS_BITS = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_char_code,
    input  logic                i_end_of_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_range_valid,
    output logic                o_first_present,
    output logic [POS_BITS-1:0] o_first_pos,
    output logic                o_last_present,
    output logic [POS_BITS-1:0] o_last_pos,
    output logic                o_done_res,
    output logic                o_status
);

    logic                w_item_valid;
    logic [7:0]          w_char_code;
    logic                w_end_of_value;
    logic                w_advance;
    logic                w_fire;
    brp_pkg::t_flags     w_flags;
    logic [POS_BITS-1:0] w_first_pos;
    logic [POS_BITS-1:0] w_last_pos;

    // item in the input register is parsed when the result register can take it
    assign w_fire = w_item_valid && w_advance;

    brp_in_reg u_in_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_end_of_value (i_end_of_value),
        .i_advance      (w_advance),
        .o_item_valid   (w_item_valid),
        .o_char_code    (w_char_code),
        .o_end_of_value (w_end_of_value)
    );

    brp_core #(.POS_BITS(POS_BITS)) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_char_code    (w_char_code),
        .i_end_of_value (w_end_of_value),
        .o_flags        (w_flags),
        .o_first_pos    (w_first_pos),
        .o_last_pos     (w_last_pos)
    );

    brp_out_reg #(.POS_BITS(POS_BITS)) u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_flags         (w_flags),
        .i_first_pos     (w_first_pos),
        .i_last_pos      (w_last_pos),
        .o_advance       (w_advance),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_range_valid   (o_range_valid),
        .o_first_present (o_first_present),
        .o_first_pos     (o_first_pos),
        .o_last_present  (o_last_present),
        .o_last_pos      (o_last_pos),
        .o_done_res      (o_done_res),
        .o_status        (o_status)
    );

endmodule

// File: verif/http_byte_range_parser_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_byte_range_parser_top_tb: self-checking bench of the range header parser
// Feeds header values one character per item, predicts every range and done
// item in a scoreboard, and compares them with what the block gives out.
// ----------------------------------------------------------------------------
package brp_tb_pkg;

    localparam int          POS_BITS  = 48;
    localparam logic [63:0] POS_MAX   = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - POS_BITS);
    localparam logic [39:0] UNIT_TEXT = "bytes";

    // one result item of the parser
    typedef struct {
        logic                range_valid;
        logic                first_present;
        logic [POS_BITS-1:0] first_pos;
        logic                last_present;
        logic [POS_BITS-1:0] last_pos;
        logic                done_res;
        logic                status;
    } t_range_item;

    class range_scoreboard;
        t_range_item due_results[$];
        int          errors;

        // parser state as predicted
        brp_pkg::t_phase phase;
        logic [2:0]      unit_idx;
        bit              unit_bad;
        brp_pkg::t_spec  spec;
        logic [63:0]     first_acc;
        bit              first_seen;
        logic [63:0]     second_acc;
        bit              second_seen;
        bit              parse_err;
        t_range_item     cur;

        function new();
            errors = 0;
            restart();
        endfunction

        function void clear_spec();
            spec        = brp_pkg::SP_START;
            first_acc   = '0;
            first_seen  = 1'b0;
            second_acc  = '0;
            second_seen = 1'b0;
        endfunction

        function void restart();
            phase     = brp_pkg::PH_LEAD;
            unit_idx  = '0;
            unit_bad  = 1'b0;
            parse_err = 1'b0;
            clear_spec();
        endfunction

        // times-ten accumulate, saturating at the position maximum
        function logic [63:0] push_digit(logic [63:0] acc, logic [63:0] d);
            if (acc > (POS_MAX - d) / 10)
                return POS_MAX;
            return acc * 10 + d;
        endfunction

        // close the open spec; a complete one fills the current result
        function bit close_spec();
            bit give;
            give = 1'b0;
            if (!parse_err) begin
                if (spec == brp_pkg::SP_FIRST) begin
                    parse_err = 1'b1;
                end else if (spec == brp_pkg::SP_SECOND) begin
                    cur.range_valid   = 1'b1;
                    cur.first_present = first_seen;
                    cur.first_pos     = first_acc[POS_BITS-1:0];
                    cur.last_present  = second_seen;
                    cur.last_pos      = second_acc[POS_BITS-1:0];
                    give = 1'b1;
                end
            end
            clear_spec();
            return give;
        endfunction

        function void unit_char(logic [7:0] c);
            if (unit_idx < brp_pkg::UNIT_LEN) begin
                if (UNIT_TEXT[39 - 8 * unit_idx -: 8] != c)
                    unit_bad = 1'b1;
                unit_idx++;
            end else begin
                unit_bad = 1'b1;
            end
        endfunction

        function bit set_char(logic [7:0] c);
            bit digit;
            digit = (c >= brp_pkg::CH_ZERO) && (c <= brp_pkg::CH_NINE);
            if (parse_err)
                return 1'b0;
            if (c == brp_pkg::CH_COMMA)
                return close_spec();
            case (spec)
                brp_pkg::SP_START: begin
                    if (digit) begin
                        first_acc  = 64'(c - brp_pkg::CH_ZERO);
                        first_seen = 1'b1;
                        spec       = brp_pkg::SP_FIRST;
                    end else if (c == brp_pkg::CH_DASH) begin
                        spec = brp_pkg::SP_SECOND;
                    end else begin
                        parse_err = 1'b1;
                    end
                end
                brp_pkg::SP_FIRST: begin
                    if (digit)
                        first_acc = push_digit(first_acc, 64'(c - brp_pkg::CH_ZERO));
                    else if (c == brp_pkg::CH_DASH)
                        spec = brp_pkg::SP_SECOND;
                    else
                        parse_err = 1'b1;
                end
                default: begin
                    if (digit) begin
                        second_acc  = push_digit(second_acc, 64'(c - brp_pkg::CH_ZERO));
                        second_seen = 1'b1;
                    end else begin
                        parse_err = 1'b1;
                    end
                end
            endcase
            return 1'b0;
        endfunction

        // accepted input item: advance the prediction, queue any result
        function void note_char(logic [7:0] c, logic eov);
            bit give;
            give = 1'b0;
            cur  = '{default: '0};
            if (eov) begin
                if (phase == brp_pkg::PH_SET)
                    void'(close_spec());
                cur.done_res = 1'b1;
                cur.status   = parse_err;
                restart();
                give = 1'b1;
            end else begin
                case (phase)
                    brp_pkg::PH_LEAD: begin
                        if (c != brp_pkg::CH_EQ) begin
                            phase = brp_pkg::PH_UNIT;
                            unit_char(c);
                        end
                    end
                    brp_pkg::PH_UNIT: begin
                        if (c == brp_pkg::CH_EQ) begin
                            if (unit_bad || unit_idx != brp_pkg::UNIT_LEN)
                                phase = brp_pkg::PH_IGNORE;
                            else
                                phase = brp_pkg::PH_MID;
                        end else begin
                            unit_char(c);
                        end
                    end
                    brp_pkg::PH_MID: begin
                        if (c != brp_pkg::CH_EQ) begin
                            phase = brp_pkg::PH_SET;
                            give  = set_char(c);
                        end
                    end
                    brp_pkg::PH_SET: begin
                        if (c == brp_pkg::CH_EQ) begin
                            give  = close_spec();
                            phase = brp_pkg::PH_IGNORE;
                        end else begin
                            give = set_char(c);
                        end
                    end
                    default: ;
                endcase
            end
            if (give)
                due_results = {due_results, cur};
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // accepted result item: compare with the oldest prediction
        task check_result(t_range_item got);
            t_range_item want;
            if (due_results.size() == 0) begin
                report("result item with no prediction pending");
                return;
            end
            want = due_results.pop_front();
            compare_field("range_valid", 64'(got.range_valid), 64'(want.range_valid));
            compare_field("first_present", 64'(got.first_present), 64'(want.first_present));
            compare_field("first_pos", 64'(got.first_pos), 64'(want.first_pos));
            compare_field("last_present", 64'(got.last_present), 64'(want.last_present));
            compare_field("last_pos", 64'(got.last_pos), 64'(want.last_pos));
            compare_field("done_res", 64'(got.done_res), 64'(want.done_res));
            compare_field("status", 64'(got.status), 64'(want.status));
        endtask
    endclass

endpackage

module http_byte_range_parser_top_tb;

    localparam int ITEM_TARGET    = 1800;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int POS_BITS       = brp_tb_pkg::POS_BITS;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic [7:0]          i_char_code    = '0;
    logic                i_end_of_value = 1'b0;
    logic                i_stall        = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                o_range_valid;
    logic                o_first_present;
    logic [POS_BITS-1:0] o_first_pos;
    logic                o_last_present;
    logic [POS_BITS-1:0] o_last_pos;
    logic                o_done_res;
    logic                o_status;

    brp_tb_pkg::range_scoreboard sb = new();
    brp_tb_pkg::t_range_item     seen_item;
    logic [7:0]                  text_q[$];
    int                          items_sent = 0;
    int                          burst_left = 0;
    bit                          gap_free   = 1'b0;
    bit                          hold_req   = 1'b0;

    http_byte_range_parser_top #(
        .POS_BITS(POS_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_end_of_value (i_end_of_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_range_valid  (o_range_valid),
        .o_first_present(o_first_present),
        .o_first_pos    (o_first_pos),
        .o_last_present (o_last_present),
        .o_last_pos     (o_last_pos),
        .o_done_res     (o_done_res),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    // both handshakes sampled at the edge, input side first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_char(i_char_code, i_end_of_value);
            if (o_valid && !i_stall) begin
                seen_item.range_valid   = o_range_valid;
                seen_item.first_present = o_first_present;
                seen_item.first_pos     = o_first_pos;
                seen_item.last_present  = o_last_present;
                seen_item.last_pos      = o_last_pos;
                seen_item.done_res      = o_done_res;
                seen_item.status        = o_status;
                sb.check_result(seen_item);
            end
        end
    end

    // receiver: stall pattern that changes mode now and then, plus long holds
    initial begin : receiver
        int mode;
        int hold_cnt;
        mode     = 0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = $urandom_range(150, 250);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
            if ($urandom_range(0, 47) == 0)
                mode = $urandom_range(0, 3);
        end
    end

    // watchdog on cycles with no item moving on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // one input item, with a random gap between bursts
    task automatic send_char(input logic [7:0] c, input logic eov);
        if (!gap_free && burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        i_valid        <= 1'b1;
        i_char_code    <= c;
        i_end_of_value <= eov;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // the collected header value followed by its end marker
    task automatic send_text();
        foreach (text_q[k])
            send_char(text_q[k], 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
        text_q.delete();
    endtask

    task automatic drain_wait();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_results.size() != 0)
            @(posedge i_clk);
    endtask

    // append one character to the value being built
    function automatic void add_byte(logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++)
            add_byte(s[k]);
    endfunction

    // mostly short numbers, now and then long enough to saturate
    function automatic void add_num();
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 4);
        repeat (n) add_byte(brp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] pick_noise();
        case ($urandom_range(0, 5)) inside
            0, 1:    return 8'($urandom_range(0, 255));
            2:       return brp_pkg::CH_EQ;
            3:       return brp_pkg::CH_COMMA;
            4:       return brp_pkg::CH_DASH;
            default: return brp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic void add_bad_unit();
        string unit_s;
        unit_s = "bytes";
        case ($urandom_range(0, 3))
            0: begin
                add_str(unit_s);
                text_q[text_q.size() - 1 - $urandom_range(0, 4)] = pick_noise();
            end
            1: add_str(unit_s.substr(0, $urandom_range(0, 3)));
            2: begin
                add_str(unit_s);
                add_byte(pick_noise());
            end
            default: add_str("Bytes");
        endcase
    endfunction

    // random header value: mostly well formed, some broken or pure noise
    task automatic random_value();
        int roll;
        int n_specs;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            repeat ($urandom_range(0, 12)) add_byte(pick_noise());
        end else begin
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
                add_byte(brp_pkg::CH_EQ);
            if (roll < 18)
                add_bad_unit();
            else
                add_str("bytes");
            if ($urandom_range(0, 19) != 0) begin
                repeat ($urandom_range(1, 2)) add_byte(brp_pkg::CH_EQ);
                n_specs = $urandom_range(1, 4);
                for (int k = 0; k < n_specs; k++) begin
                    if (k > 0)
                        add_byte(brp_pkg::CH_COMMA);
                    case ($urandom_range(0, 7)) inside
                        0, 1, 2: begin
                            add_num();
                            add_byte(brp_pkg::CH_DASH);
                            add_num();
                        end
                        3: begin
                            add_num();
                            add_byte(brp_pkg::CH_DASH);
                        end
                        4: begin
                            add_byte(brp_pkg::CH_DASH);
                            add_num();
                        end
                        5:       add_byte(brp_pkg::CH_DASH);
                        6:       ;
                        default: add_num();
                    endcase
                end
                if ($urandom_range(0, 9) == 0)
                    add_byte(brp_pkg::CH_COMMA);
                if ($urandom_range(0, 9) == 0) begin
                    add_byte(brp_pkg::CH_EQ);
                    repeat ($urandom_range(0, 4)) add_byte(pick_noise());
                end
            end
            if ($urandom_range(0, 9) == 0 && text_q.size() != 0)
                text_q[$urandom_range(0, text_q.size() - 1)] = pick_noise();
        end
        send_text();
    endtask

    // long receiver hold while the sender keeps offering items
    task automatic hold_off_burst();
        hold_req = 1'b1;
        gap_free = 1'b1;
        repeat (4) random_value();
        gap_free = 1'b0;
        drain_wait();
    endtask

    initial begin : stimulus
        bit mid_hold;
        mid_hold = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed values: plain, suffix, lone dash, saturation, unit faults
        add_str("bytes=0-0");
        send_text();
        add_str("bytes=-500");
        send_text();
        add_str("bytes=1-2,-");
        send_text();
        add_str("bytes=7");
        send_text();
        add_str("bytes=281474976710655-281474976710656");
        send_text();
        add_str("bytes=99999999999999999999-,5-3-");
        send_text();
        add_str("==bytes==1-2,,3-,=9-9");
        send_text();
        add_str("Bytes=0-1");
        send_text();
        add_str("bytesx=0-1");
        send_text();
        add_str("byte=0-1");
        send_text();
        add_str("bytes");
        send_text();
        add_str("bytes==");
        send_text();
        send_text();
        add_str("bytes=1-2,x,3-4");
        send_text();
        // zero and high bytes inside a spec and inside the unit
        add_str("bytes=1");
        add_byte(8'h00);
        send_text();
        add_str("bytes=0-9,");
        add_byte(8'hFF);
        add_str(",2-3");
        send_text();
        add_byte(8'h80);
        add_str("bytes=1-2");
        send_text();
        add_str("byt");
        add_byte(8'h00);
        add_str("s=1-1");
        send_text();
        drain_wait();

        hold_off_burst();

        // random values, with a second hold about halfway
        while (items_sent < ITEM_TARGET) begin
            gap_free = ($urandom_range(0, 4) == 0);
            random_value();
            if (!mid_hold && items_sent >= ITEM_TARGET / 2) begin
                mid_hold = 1'b1;
                hold_off_burst();
            end
        end
        gap_free = 1'b0;

        drain_wait();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
